[hdl/utx_pkg.sv]
// ----------------------------------------------------------------------------
// utx_pkg: shared types and constants for the UDP transmit checksum unit
// Item formats, queue entry, register indexes and ones-complement helpers.
// ----------------------------------------------------------------------------
package utx_pkg;

  localparam int unsigned MaxPayload  = 65507;
  localparam int unsigned UdpHdrBytes = 8;
  localparam int unsigned IpHdrBytes  = 20;
  localparam int unsigned ProtoUdp    = 17;
  localparam int unsigned CountW      = 17;
  localparam int unsigned QDepth      = 2;
  localparam int unsigned QPtrW       = $clog2(QDepth);
  localparam int unsigned QCntW       = $clog2(QDepth + 1);

  localparam logic [CountW-1:0] CountTop = {CountW{1'b1}};

  typedef enum logic [1:0] {
    CfgSrcAddr  = 2'd0,
    CfgDstAddr  = 2'd1,
    CfgSrcPort  = 2'd2,
    CfgDstPort  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       end_of_datagram;
  } in_item_t;

  typedef struct packed {
    logic [15:0] udp_length;
    logic [15:0] ip_total_length;
    logic [15:0] udp_checksum;
    logic        too_long;
  } out_item_t;

  // One closed datagram handed from the front to the back.
  typedef struct packed {
    logic [15:0]       sum;    // folded sum of all complete words
    logic [15:0]       pad;    // odd trailing byte padded, or zero
    logic [CountW-1:0] count;  // saturating byte count
  } dgram_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

  // Ones-complement add of two 16-bit words.
  function automatic logic [15:0] oc_add(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    logic [16:0] f;
    s = {1'b0, a} + {1'b0, b};
    f = {1'b0, s[15:0]} + {16'h0, s[16]};
    return f[15:0];
  endfunction

  // End-around fold of a 19-bit sum down to 16 bits.
  function automatic logic [15:0] fold19(logic [18:0] s);
    logic [16:0] f1;
    logic [16:0] f2;
    f1 = {1'b0, s[15:0]} + {14'h0, s[18:16]};
    f2 = {1'b0, f1[15:0]} + {16'h0, f1[16]};
    return f2[15:0];
  endfunction

endpackage

[hdl/udp_tx_header_checksum_unit.sv]
// A closed datagram passes through the queue and then the output register.
// Throughput: one item per cycle unless stalled; a new datagram may follow at once.
// The two-entry datagram queue between accumulator and finisher absorbs
// output stalls; input stalls only when the queue is full.
// Reset (rst_ni low, asynchronous) clears registers, sums, counts and queue.
// ----------------------------------------------------------------------------
// udp_tx_header_checksum_unit: UDP length and checksum for outgoing datagrams
// Payload bytes in, one result per datagram with lengths and checksum out.
// ----------------------------------------------------------------------------
module udp_tx_header_checksum_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_addr_i,
  input  logic [31:0]        cfg_wdata_i,
  // payload items
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  utx_pkg::in_item_t  in_item_i,
  // results
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output utx_pkg::out_item_t out_item_o
);
  import utx_pkg::*;

  logic [31:0] src_addr_q, dst_addr_q;
  logic [15:0] src_port_q, dst_port_q;
  logic [15:0] hdr_sum_q;
  logic [18:0] hdr_wide;

  q_stat_t q_stat;
  dgram_t  push_data, head;
  logic    push, pop;

  // Connection registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_addr_q <= '0;
      dst_addr_q <= '0;
      src_port_q <= '0;
      dst_port_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CfgSrcAddr: src_addr_q <= cfg_wdata_i;
        CfgDstAddr: dst_addr_q <= cfg_wdata_i;
        CfgSrcPort: src_port_q <= cfg_wdata_i[15:0];
        CfgDstPort: dst_port_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // Fixed part of pseudo-header plus UDP header (everything but the lengths).
  // Registered; config must change only while idle, which the block does not check,
  // so the lag of this register is hidden behind the front and queue.
  assign hdr_wide = {3'b0, src_addr_q[31:16]} + {3'b0, src_addr_q[15:0]}
                  + {3'b0, dst_addr_q[31:16]} + {3'b0, dst_addr_q[15:0]}
                  + 19'(ProtoUdp) + {3'b0, src_port_q} + {3'b0, dst_port_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_sum_q <= 16'(ProtoUdp);
    end else begin
      hdr_sum_q <= fold19(hdr_wide);
    end
  end

  // Front: accepts bytes, keeps the running sum, closes datagrams.
  utx_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Queue of closed datagrams.
  utx_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .q_stat_o    (q_stat)
  );

  // Back: header sum, complement and output register.
  utx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .head_i      (head),
    .hdr_sum_i   (hdr_sum_q),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // Front never pushes into a full queue.
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full) else $error("push into full queue");

  // A checksum of zero is always sent as all ones.
  a_cks_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.udp_checksum != 16'h0000)
    else $error("zero checksum emitted");

  // Overlong payload saturates the UDP length.
  a_sat_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.too_long |->
      out_item_o.udp_length == 16'(MaxPayload + UdpHdrBytes))
    else $error("length not saturated");

  // A pop always leaves a valid result in the next cycle.
  a_pop_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> out_valid_o) else $error("popped datagram lost");

endmodule

[hdl/utx_front.sv]
// ----------------------------------------------------------------------------
// utx_front: payload accumulator
// Pairs bytes into big-endian words, keeps the folded sum and byte count,
// and pushes one entry per datagram into the queue.
// ----------------------------------------------------------------------------
module utx_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  utx_pkg::in_item_t in_item_i,
  input  utx_pkg::q_stat_t  q_stat_i,
  output logic              push_o,
  output utx_pkg::dgram_t   push_data_o
);
  import utx_pkg::*;

  logic [15:0]       sum_q, sum_d;
  logic [7:0]        held_q, held_d;
  logic              odd_q, odd_d;
  logic [CountW-1:0] count_q, count_d;
  logic              accept;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !q_stat_i.full;

  always_comb begin
    sum_d   = sum_q;
    held_d  = held_q;
    odd_d   = odd_q;
    count_d = count_q;
    if (in_item_i.byte_valid) begin
      if (odd_q) begin
        sum_d  = oc_add(sum_q, {held_q, in_item_i.payload_byte});
        odd_d  = 1'b0;
        held_d = 8'h00;
      end else begin
        held_d = in_item_i.payload_byte;
        odd_d  = 1'b1;
      end
      if (count_q != CountTop) begin
        count_d = count_q + CountW'(1);
      end
    end
  end

  assign push_o            = accept && in_item_i.end_of_datagram;
  assign push_data_o.sum   = sum_d;
  assign push_data_o.pad   = odd_d ? {held_d, 8'h00} : 16'h0000;
  assign push_data_o.count = count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      held_q  <= '0;
      odd_q   <= 1'b0;
      count_q <= '0;
    end else if (accept) begin
      if (in_item_i.end_of_datagram) begin
        sum_q   <= '0;
        held_q  <= '0;
        odd_q   <= 1'b0;
        count_q <= '0;
      end else begin
        sum_q   <= sum_d;
        held_q  <= held_d;
        odd_q   <= odd_d;
        count_q <= count_d;
      end
    end
  end

endmodule

[hdl/utx_queue.sv]
// ----------------------------------------------------------------------------
// utx_queue: short FIFO between front and back
// Holds closed datagrams so each side can stall on its own.
// ----------------------------------------------------------------------------
module utx_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  utx_pkg::dgram_t  push_data_i,
  input  logic             pop_i,
  output utx_pkg::dgram_t  head_o,
  output utx_pkg::q_stat_t q_stat_o
);
  import utx_pkg::*;

  dgram_t            mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  cnt_q;
  logic              do_push, do_pop;

  assign q_stat_o.full      = (cnt_q == QCntW'(QDepth));
  assign q_stat_o.not_empty = (cnt_q != '0);
  assign do_push            = push_i && !q_stat_o.full;
  assign do_pop             = pop_i && q_stat_o.not_empty;
  assign head_o             = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

endmodule

[hdl/utx_back.sv]
// ----------------------------------------------------------------------------
// utx_back: header finish and result register
// Clamps the length, adds pseudo-header and UDP header, complements.
// ----------------------------------------------------------------------------
module utx_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  utx_pkg::q_stat_t   q_stat_i,
  input  utx_pkg::dgram_t    head_i,
  input  logic [15:0]        hdr_sum_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output utx_pkg::out_item_t out_item_o
);
  import utx_pkg::*;

  logic        over;
  logic [15:0] plen, ulen, folded, cks;
  logic [18:0] wide;
  out_item_t   res_d, res_q;
  logic        valid_q;

  assign over   = head_i.count > CountW'(MaxPayload);
  assign plen   = over ? 16'(MaxPayload) : head_i.count[15:0];
  assign ulen   = plen + 16'(UdpHdrBytes);
  // Length enters twice: once in the pseudo-header, once in the UDP header.
  assign wide   = {3'b0, head_i.sum} + {3'b0, head_i.pad} + {3'b0, hdr_sum_i}
                + {3'b0, ulen} + {3'b0, ulen};
  assign folded = fold19(wide);
  assign cks    = (~folded == 16'h0000) ? 16'hFFFF : ~folded;

  assign res_d.udp_length      = ulen;
  assign res_d.ip_total_length = ulen + 16'(IpHdrBytes);
  assign res_d.udp_checksum    = cks;
  assign res_d.too_long        = over;

  assign pop_o       = q_stat_i.not_empty && (!valid_q || !out_stall_i);
  assign out_valid_o = valid_q;
  assign out_item_o  = res_q;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for udp_tx_header_checksum_unit
// Drives payload bytes under random idling and output stalls, predicts the
// UDP length, IP total length, checksum and overlong flag for every closed
// datagram, and compares each result with the oldest prediction in order.
// ----------------------------------------------------------------------------
module tb_top;
  import utx_pkg::*;

  localparam int unsigned IdlePct      = 38;
  localparam int unsigned SettleCycles = 4;      // result latency plus margin
  localparam int unsigned DrainLimit   = 20000;  // cycles to wait for results
  localparam int unsigned PhaseItems   = 190;
  localparam int unsigned NumRows      = 19;

  localparam out_item_t NoRes = '0;

  // One directed item; typed marks a result written in by hand.
  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t res;
  } row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_addr_i  = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_item_t    in_item_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_item_o;

  // Connection settings as the block should hold them.
  logic [31:0] conn_src   = '0;
  logic [31:0] conn_dst   = '0;
  logic [15:0] conn_sport = '0;
  logic [15:0] conn_dport = '0;

  // Running datagram state of the predictor.
  logic [15:0]       word_sum = '0;
  logic [CountW-1:0] byte_cnt = '0;
  logic [7:0]        hi_byte  = '0;
  logic              odd_byte = 1'b0;

  out_item_t   pending_results[$];
  int unsigned fail_count = 0;
  int unsigned items_sent = 0;
  logic        steady     = 1'b0;  // both sides run without idling

  // Directed items, run with all connection settings at their reset value.
  row_t directed_rows [NumRows] = '{
    // empty datagram: only protocol and twice the UDP length enter the sum
    '{'{8'h00, 1'b0, 1'b1}, 1'b1, '{16'd8, 16'd28, 16'hFFDE, 1'b0}},
    // sum folds to all ones, so the zero checksum goes out as FFFF
    '{'{8'hFF, 1'b1, 1'b0}, 1'b0, NoRes},
    '{'{8'hDA, 1'b1, 1'b1}, 1'b1, '{16'd10, 16'd30, 16'hFFFF, 1'b0}},
    // invalid items in a datagram, one of them between the halves of a word
    '{'{8'hAA, 1'b0, 1'b0}, 1'b0, NoRes},
    '{'{8'h12, 1'b1, 1'b0}, 1'b0, NoRes},
    '{'{8'h55, 1'b0, 1'b0}, 1'b0, NoRes},
    '{'{8'h34, 1'b1, 1'b1}, 1'b0, NoRes},
    // invalid closing item after an odd byte count
    '{'{8'h01, 1'b1, 1'b0}, 1'b0, NoRes},
    '{'{8'h02, 1'b1, 1'b0}, 1'b0, NoRes},
    '{'{8'h03, 1'b1, 1'b0}, 1'b0, NoRes},
    '{'{8'hFF, 1'b0, 1'b1}, 1'b0, NoRes},
    // single byte, padded with a zero low byte
    '{'{8'h80, 1'b1, 1'b1}, 1'b0, NoRes},
    // all-ones payload
    '{'{8'hFF, 1'b1, 1'b0}, 1'b0, NoRes},
    '{'{8'hFF, 1'b1, 1'b0}, 1'b0, NoRes},
    '{'{8'hFF, 1'b1, 1'b0}, 1'b0, NoRes},
    '{'{8'hFF, 1'b1, 1'b1}, 1'b0, NoRes},
    // all-zero payload
    '{'{8'h00, 1'b1, 1'b0}, 1'b0, NoRes},
    '{'{8'h00, 1'b1, 1'b1}, 1'b1, '{16'd10, 16'd30, 16'hFFDA, 1'b0}},
    // empty datagram straight after another one
    '{'{8'h00, 1'b0, 1'b1}, 1'b1, '{16'd8, 16'd28, 16'hFFDE, 1'b0}}
  };

  udp_tx_header_checksum_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always #6 clk_i = ~clk_i;

  // End-around carry add of two 16-bit words.
  function automatic logic [15:0] fold_add(logic [15:0] a, logic [15:0] b);
    logic [16:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[15:0] + {15'h0, t[16]};
  endfunction

  // Absorbs one accepted item; returns 1 with the result on a closing item.
  function automatic bit udp_csum_model(input in_item_t it, output out_item_t res);
    logic [15:0]       s;
    logic [15:0]       cks;
    logic [CountW-1:0] plen;
    logic [15:0]       ulen;
    logic              over;
    res = NoRes;
    if (it.byte_valid) begin
      if (odd_byte) begin
        word_sum = fold_add(word_sum, {hi_byte, it.payload_byte});
        hi_byte  = '0;
        odd_byte = 1'b0;
      end else begin
        hi_byte  = it.payload_byte;
        odd_byte = 1'b1;
      end
      if (byte_cnt != CountTop) byte_cnt = byte_cnt + CountW'(1);
    end
    if (!it.end_of_datagram) return 1'b0;

    s = word_sum;
    if (odd_byte) s = fold_add(s, {hi_byte, 8'h00});
    over = byte_cnt > CountW'(MaxPayload);
    plen = over ? CountW'(MaxPayload) : byte_cnt;
    ulen = 16'(plen + UdpHdrBytes);
    // pseudo-header, then UDP header with the length counted a second time
    s = fold_add(s, conn_src[31:16]);
    s = fold_add(s, conn_src[15:0]);
    s = fold_add(s, conn_dst[31:16]);
    s = fold_add(s, conn_dst[15:0]);
    s = fold_add(s, 16'(ProtoUdp));
    s = fold_add(s, ulen);
    s = fold_add(s, conn_sport);
    s = fold_add(s, conn_dport);
    s = fold_add(s, ulen);
    cks = ~s;

    res.udp_length      = ulen;
    res.ip_total_length = ulen + 16'(IpHdrBytes);
    res.udp_checksum    = (cks == 16'h0000) ? 16'hFFFF : cks;
    res.too_long        = over;
    word_sum = '0;
    byte_cnt = '0;
    hi_byte  = '0;
    odd_byte = 1'b0;
    return 1'b1;
  endfunction

  // Entered and left at a falling edge; valid stays high into the next item.
  task automatic push_item(input in_item_t it, input logic typed, input out_item_t typed_res);
    out_item_t res;
    while (!steady && $urandom_range(0, 99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    if (udp_csum_model(it, res)) pending_results.push_back(typed ? typed_res : res);
    if (it.byte_valid || it.end_of_datagram) items_sent++;
    @(negedge clk_i);
  endtask

  // Holds the sender off until every predicted result has been taken.
  task automatic wait_drained();
    int unsigned waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0 && waited < DrainLimit) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Writes all four registers; port writes carry junk in the unused bits.
  task automatic load_connection(input logic [31:0] src, input logic [31:0] dst,
                                 input logic [15:0] sport, input logic [15:0] dport);
    cfg_idx_e    idx;
    logic [31:0] val;
    int          k;
    for (k = 0; k < 4; k++) begin
      idx = cfg_idx_e'(k);
      case (idx)
        CfgSrcAddr: val = src;
        CfgDstAddr: val = dst;
        CfgSrcPort: val = {16'($urandom), sport};
        default:    val = {16'($urandom), dport};
      endcase
      cfg_we_i    <= 1'b1;
      cfg_addr_i  <= idx;
      cfg_wdata_i <= val;
      @(negedge clk_i);
    end
    cfg_we_i   <= 1'b0;
    conn_src   = src;
    conn_dst   = dst;
    conn_sport = sport;
    conn_dport = dport;
  endtask

  // Mostly short datagrams, some noise items and invalid closing items.
  task automatic send_random_datagram();
    int unsigned len;
    int unsigned pick;
    int unsigned k;
    logic        open_end;
    in_item_t    it;
    pick = $urandom_range(0, 99);
    if (pick < 10) len = 0;
    else if (pick < 70) len = $urandom_range(1, 16);
    else if (pick < 92) len = $urandom_range(17, 64);
    else len = $urandom_range(65, 300);
    open_end = (len == 0) || ($urandom_range(0, 99) < 15);
    for (k = 0; k < len; k++) begin
      if ($urandom_range(0, 99) < 8) begin
        it = '{8'($urandom), 1'b0, 1'b0};
        push_item(it, 1'b0, NoRes);
      end
      it = '{8'($urandom), 1'b1, (!open_end && k == len - 1)};
      push_item(it, 1'b0, NoRes);
    end
    if (open_end) begin
      it = '{8'($urandom), 1'b0, 1'b1};
      push_item(it, 1'b0, NoRes);
    end
  endtask

  task automatic run_phase(input logic [31:0] src, input logic [31:0] dst,
                           input logic [15:0] sport, input logic [15:0] dport,
                           input logic no_idle, input logic mid_pause);
    int unsigned first;
    logic        paused;
    wait_drained();
    load_connection(src, dst, sport, dport);
    steady <= no_idle;
    first  = items_sent;
    paused = 1'b0;
    while (items_sent - first < PhaseItems) begin
      send_random_datagram();
      // sender holds off once mid-phase until the output side has caught up
      if (mid_pause && !paused && items_sent - first >= PhaseItems / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  task automatic send_long_datagram(input int unsigned nbytes);
    int unsigned k;
    in_item_t    it;
    for (k = 1; k <= nbytes; k++) begin
      it = '{8'($urandom), 1'b1, (k == nbytes)};
      push_item(it, 1'b0, NoRes);
    end
  endtask

  // Result side stalls at random unless a steady stretch is running.
  always @(negedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(0, 99) < IdlePct);
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: %p", out_item_o);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_item_o.udp_length !== want.udp_length) begin
          $error("udp_length: expected %0d, got %0d", want.udp_length, out_item_o.udp_length);
          fail_count++;
        end
        if (out_item_o.ip_total_length !== want.ip_total_length) begin
          $error("ip_total_length: expected %0d, got %0d",
                 want.ip_total_length, out_item_o.ip_total_length);
          fail_count++;
        end
        if (out_item_o.udp_checksum !== want.udp_checksum) begin
          $error("udp_checksum: expected %h, got %h", want.udp_checksum, out_item_o.udp_checksum);
          fail_count++;
        end
        if (out_item_o.too_long !== want.too_long) begin
          $error("too_long: expected %b, got %b", want.too_long, out_item_o.too_long);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int unsigned r;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (r = 0; r < NumRows; r++) begin
      push_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].res);
    end

    // settings: all ones, random, mixed extremes, random
    run_phase('1, '1, '1, '1, 1'b0, 1'b0);
    run_phase($urandom, $urandom, 16'($urandom), 16'($urandom), 1'b0, 1'b1);
    run_phase('1, '0, '0, '1, 1'b1, 1'b0);
    run_phase($urandom, $urandom, 16'($urandom), 16'($urandom), 1'b0, 1'b0);

    // largest legal payload, one byte over, and enough bytes to pin the count
    wait_drained();
    load_connection($urandom, $urandom, 16'($urandom), 16'($urandom));
    steady <= 1'b1;
    send_long_datagram(MaxPayload);
    send_long_datagram(MaxPayload + 1);
    send_long_datagram(int'(CountTop) + 2);
    steady <= 1'b0;

    wait_drained();
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      fail_count += pending_results.size();
    end
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(36_000_000);
    $display("TB_ERROR");
    $finish;
  end

endmodule

[filelist.f]
hdl/utx_pkg.sv
hdl/utx_front.sv
hdl/utx_queue.sv
hdl/utx_back.sv
hdl/udp_tx_header_checksum_unit.sv
sim/tb_top.sv
